// ===== sv/fsbc_pkg.sv =====
// Shared types and constants for the flash sector and block cache controller.
package fsbc_pkg;

	// Fixed field widths of the request, result and configuration ports
	localparam int BLOCK_IN_W  = 16;
	localparam int PART_W      = 17;
	localparam int CFG_IDX_W   = 1;
	localparam int SECTOR_W    = 13;
	localparam int SLOT_OUT_W  = 3;
	localparam int POS_OUT_W   = 3;
	localparam int CMD_W       = 4;

	// Reciprocal scale for the divide-by-sector-size step
	localparam int DIV_SHIFT   = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PARTITION_BLOCKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_READY     = 1'b1;

	// Result commands
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE      = 4'd0,
		CMD_COPY_BUF  = 4'd1,
		CMD_COPY_SLOT = 4'd2,
		CMD_FILL_SLOT = 4'd3,
		CMD_WRITE_BUF = 4'd4,
		CMD_ERASE     = 4'd5,
		CMD_PROGRAM   = 4'd6,
		CMD_REFRESH   = 4'd7,
		CMD_LOAD      = 4'd8
	} cmd_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_MUL,
		ST_DIV_REM,
		ST_DIV_FIX,
		ST_DECIDE,
		ST_RD_SCAN,
		ST_FILL,
		ST_PROGRAM,
		ST_REFRESH,
		ST_LOAD,
		ST_WRITE
	} state_t;

	// Sequencer to slot store
	typedef struct packed {
		logic scan_start;
		logic scan_stop;
		logic fill;
	} slot_ctl_t;

	// Slot store to sequencer, one compared slot per cycle
	typedef struct packed {
		logic act;
		logic hit;
		logic insec;
		logic last;
	} slot_sts_t;

	// One result beat
	typedef struct packed {
		logic                  status;
		cmd_t                  command;
		logic [SECTOR_W-1:0]   sector;
		logic [SLOT_OUT_W-1:0] slot;
		logic [POS_OUT_W-1:0]  pos;
		logic                  last;
	} result_t;

endpackage

// ===== sv/flash_sector_and_block_cache_control_top.sv =====
// A rejected request answers in the cycle after start; others pass the three divide steps and decide first.
// A read that misses the buffer scans one slot per cycle, until a hit or the last slot.
// A write miss emits erase, program, refreshes, load, write.
// busy stays high through each accepted request (not for a rejected one), spanning the
// three-step reciprocal divide and the one-slot-per-cycle tag compare. No result stall.
// Reset: sector 0 buffered, all slots invalid, fill pointer 0, registers 0; no clearing pass.
module flash_sector_and_block_cache_control_top #(
	parameter int SLOTS             = 8,
	parameter int BLOCKS_PER_SECTOR = 8,
	parameter int BLOCK_NUMBER_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fsbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsbc_pkg::PART_W-1:0]          cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 action,
	input  logic [fsbc_pkg::BLOCK_IN_W-1:0]      block_number,
	output logic                                 result_valid,
	output logic                                 status,
	output logic [fsbc_pkg::CMD_W-1:0]           command,
	output logic [fsbc_pkg::SECTOR_W-1:0]        sector_number,
	output logic [fsbc_pkg::SLOT_OUT_W-1:0]      slot_index,
	output logic [fsbc_pkg::POS_OUT_W-1:0]       block_in_sector,
	output logic                                 last
);

	import fsbc_pkg::*;

	localparam int TAG_W = (BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;

	logic [PART_W-1:0] partition_blocks_q;
	logic              device_ready_q;
	slot_ctl_t         ctl;
	slot_sts_t         sts;
	logic [IDX_W-1:0]  slot_idx;
	logic [POS_W-1:0]  slot_pos;
	logic [IDX_W-1:0]  fill_ptr;
	logic [TAG_W-1:0]  key;
	logic [TAG_W-1:0]  base;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_blocks_q <= '0;
			device_ready_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PARTITION_BLOCKS: partition_blocks_q <= cfg_data;
				REG_DEVICE_READY:     device_ready_q     <= cfg_data[0];
				default:              device_ready_q     <= device_ready_q;
			endcase
		end
	end

	fsbc_seq #(
		.SLOTS             (SLOTS),
		.BLOCKS_PER_SECTOR (BLOCKS_PER_SECTOR),
		.BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.block_number     (block_number),
		.partition_blocks (partition_blocks_q),
		.device_ready     (device_ready_q),
		.ctl              (ctl),
		.sts              (sts),
		.slot_idx         (slot_idx),
		.slot_pos         (slot_pos),
		.fill_ptr         (fill_ptr),
		.key              (key),
		.base             (base),
		.result_valid     (result_valid),
		.status           (status),
		.command          (command),
		.sector_number    (sector_number),
		.slot_index       (slot_index),
		.block_in_sector  (block_in_sector),
		.last             (last)
	);

	fsbc_slots #(
		.SLOTS             (SLOTS),
		.BLOCKS_PER_SECTOR (BLOCKS_PER_SECTOR),
		.BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.key      (key),
		.base     (base),
		.sts      (sts),
		.idx      (slot_idx),
		.pos      (slot_pos),
		.fill_ptr (fill_ptr)
	);

endmodule

// ===== sv/fsbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsbc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/fsbc_slots.sv =====
// Read cache slot store: tag RAM, valid bits, FIFO fill pointer and the slot compare unit.
module fsbc_slots #(
	parameter int SLOTS             = 8,
	parameter int BLOCKS_PER_SECTOR = 8,
	parameter int BLOCK_NUMBER_BITS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  fsbc_pkg::slot_ctl_t                                   ctl,
	input  logic [((BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16)-1:0] key,
	input  logic [((BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16)-1:0] base,
	output fsbc_pkg::slot_sts_t                                   sts,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]          idx,
	output logic [((BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1)-1:0] pos,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]          fill_ptr
);

	import fsbc_pkg::*;

	localparam int TAG_W = (BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [TAG_W-1:0] BPS_T    = TAG_W'(BLOCKS_PER_SECTOR);

	logic             run_q;
	logic [IDX_W-1:0] cnt_q;
	logic             act_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SLOTS-1:0] valid_q;
	logic [IDX_W-1:0] fill_ptr_q;
	logic [TAG_W-1:0] tag_rd;
	logic [TAG_W-1:0] diff;
	logic             slot_ok;

	// tag storage, written on fill, read by the scan
	fsbc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ctl.fill),
		.waddr (fill_ptr_q),
		.wdata (key),
		.re    (run_q),
		.raddr (cnt_q),
		.rdata (tag_rd)
	);

	// scan sequencer: one slot address issued per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			act_s1 <= 1'b0;
		end else if (ctl.scan_start) begin
			run_q  <= 1'b1;
			cnt_q  <= '0;
			act_s1 <= 1'b0;
		end else if (ctl.scan_stop) begin
			run_q  <= 1'b0;
			act_s1 <= 1'b0;
		end else if (run_q) begin
			act_s1 <= 1'b1;
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == LAST_IDX) begin
				run_q <= 1'b0;
			end
		end else begin
			act_s1 <= 1'b0;
		end
	end

	// slot index travels with the read data
	always_ff @(posedge clk) begin
		if (run_q) begin
			idx_s1 <= cnt_q;
		end
	end

	// valid bits and FIFO fill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fill_ptr_q <= '0;
		end else if (ctl.fill) begin
			valid_q[fill_ptr_q] <= 1'b1;
			if (fill_ptr_q == LAST_IDX) begin
				fill_ptr_q <= '0;
			end else begin
				fill_ptr_q <= fill_ptr_q + 1'b1;
			end
		end
	end

	// compare unit: exact tag match and in-sector test against the buffer base
	always_comb begin
		slot_ok   = act_s1 && valid_q[idx_s1];
		diff      = tag_rd - base;
		sts.act   = act_s1;
		sts.hit   = slot_ok && (tag_rd == key);
		sts.insec = slot_ok && (tag_rd >= base) && (diff < BPS_T);
		sts.last  = act_s1 && (idx_s1 == LAST_IDX);
	end

	assign idx      = idx_s1;
	assign pos      = diff[POS_W-1:0];
	assign fill_ptr = fill_ptr_q;

	// a fill never overlaps a running scan
	a_fill_not_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill |-> !run_q)
		else $error("slot fill while tag scan running");

	// a filled slot is valid afterwards
	a_fill_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill |=> valid_q[$past(fill_ptr_q)])
		else $error("filled slot not marked valid");

endmodule

// ===== sv/fsbc_seq.sv =====
// Request sequencer: reject check, sector divide, command emission and buffer state.
module fsbc_seq #(
	parameter int SLOTS             = 8,
	parameter int BLOCKS_PER_SECTOR = 8,
	parameter int BLOCK_NUMBER_BITS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	output logic                                                  busy,
	input  logic                                                  action,
	input  logic [fsbc_pkg::BLOCK_IN_W-1:0]                       block_number,
	input  logic [fsbc_pkg::PART_W-1:0]                           partition_blocks,
	input  logic                                                  device_ready,
	output fsbc_pkg::slot_ctl_t                                   ctl,
	input  fsbc_pkg::slot_sts_t                                   sts,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]          slot_idx,
	input  logic [((BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1)-1:0] slot_pos,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]          fill_ptr,
	output logic [((BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16)-1:0] key,
	output logic [((BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16)-1:0] base,
	output logic                                                  result_valid,
	output logic                                                  status,
	output logic [fsbc_pkg::CMD_W-1:0]                            command,
	output logic [fsbc_pkg::SECTOR_W-1:0]                         sector_number,
	output logic [fsbc_pkg::SLOT_OUT_W-1:0]                       slot_index,
	output logic [fsbc_pkg::POS_OUT_W-1:0]                        block_in_sector,
	output logic                                                  last
);

	import fsbc_pkg::*;

	localparam int TAG_W   = (BLOCK_NUMBER_BITS < 16) ? BLOCK_NUMBER_BITS : 16;
	localparam int POS_W   = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;
	localparam int REM_W   = POS_W + 1;
	localparam int RECIP   = (1 << DIV_SHIFT) / BLOCKS_PER_SECTOR;
	localparam int RECIP_W = DIV_SHIFT + 1;
	localparam int PROD_W  = TAG_W + RECIP_W;
	localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);
	localparam logic [TAG_W-1:0]  BPS_T   = TAG_W'(BLOCKS_PER_SECTOR);
	localparam logic [REM_W-1:0]  BPS_R   = REM_W'(BLOCKS_PER_SECTOR);

	state_t            state_q, state_d;
	logic              accept;
	logic              reject;
	logic [TAG_W-1:0]  blk_in;
	logic              sec_hit;

	logic              action_q;
	logic [TAG_W-1:0]  blk_q;
	logic [PROD_W-1:0] prod_q;
	logic [TAG_W-1:0]  quo;
	logic [TAG_W-1:0]  rem_full;
	logic [REM_W-1:0]  rem_q;
	logic [TAG_W-1:0]  sector_q;
	logic [POS_W-1:0]  pos_q;
	logic [TAG_W-1:0]  cached_sector_q;
	logic [TAG_W-1:0]  base_q;

	logic              emit_valid;
	result_t           emit;
	logic              result_valid_q;
	result_t           res_q;

	// request decode
	always_comb begin
		busy     = (state_q != ST_IDLE);
		accept   = start && !busy;
		blk_in   = block_number[TAG_W-1:0];
		reject   = !device_ready || (PART_W'(blk_in) >= partition_blocks);
		quo      = prod_q[DIV_SHIFT +: TAG_W];
		rem_full = blk_q - quo * BPS_T;
		sec_hit  = (sector_q == cached_sector_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !reject) begin
					state_d = ST_DIV_MUL;
				end
			end
			ST_DIV_MUL: state_d = ST_DIV_REM;
			ST_DIV_REM: state_d = ST_DIV_FIX;
			ST_DIV_FIX: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sec_hit) begin
					state_d = ST_IDLE;
				end else if (!action_q) begin
					state_d = ST_RD_SCAN;
				end else begin
					state_d = ST_PROGRAM;
				end
			end
			ST_RD_SCAN: begin
				if (sts.act && sts.hit) begin
					state_d = ST_IDLE;
				end else if (sts.last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL:    state_d = ST_IDLE;
			ST_PROGRAM: state_d = ST_REFRESH;
			ST_REFRESH: begin
				if (sts.last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD:    state_d = ST_WRITE;
			ST_WRITE:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs: slot control and the result beat of this cycle
	always_comb begin
		ctl        = '0;
		emit_valid = 1'b0;
		emit       = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.scan_stop = 1'b1;
				if (accept && reject) begin
					emit_valid  = 1'b1;
					emit.status = 1'b1;
					emit.last   = 1'b1;
				end
			end
			ST_DECIDE: begin
				if (sec_hit) begin
					emit_valid   = 1'b1;
					emit.command = action_q ? CMD_WRITE_BUF : CMD_COPY_BUF;
					emit.sector  = SECTOR_W'(sector_q);
					emit.pos     = POS_OUT_W'(pos_q);
					emit.last    = 1'b1;
				end else if (!action_q) begin
					ctl.scan_start = 1'b1;
				end else begin
					emit_valid   = 1'b1;
					emit.command = CMD_ERASE;
					emit.sector  = SECTOR_W'(cached_sector_q);
				end
			end
			ST_RD_SCAN: begin
				if (sts.act && sts.hit) begin
					emit_valid   = 1'b1;
					emit.command = CMD_COPY_SLOT;
					emit.sector  = SECTOR_W'(sector_q);
					emit.slot    = SLOT_OUT_W'(slot_idx);
					emit.last    = 1'b1;
				end
			end
			ST_FILL: begin
				ctl.fill     = 1'b1;
				emit_valid   = 1'b1;
				emit.command = CMD_FILL_SLOT;
				emit.sector  = SECTOR_W'(sector_q);
				emit.slot    = SLOT_OUT_W'(fill_ptr);
				emit.last    = 1'b1;
			end
			ST_PROGRAM: begin
				ctl.scan_start = 1'b1;
				emit_valid     = 1'b1;
				emit.command   = CMD_PROGRAM;
				emit.sector    = SECTOR_W'(cached_sector_q);
			end
			ST_REFRESH: begin
				if (sts.insec) begin
					emit_valid   = 1'b1;
					emit.command = CMD_REFRESH;
					emit.sector  = SECTOR_W'(cached_sector_q);
					emit.slot    = SLOT_OUT_W'(slot_idx);
					emit.pos     = POS_OUT_W'(slot_pos);
				end
			end
			ST_LOAD: begin
				emit_valid   = 1'b1;
				emit.command = CMD_LOAD;
				emit.sector  = SECTOR_W'(sector_q);
			end
			ST_WRITE: begin
				emit_valid   = 1'b1;
				emit.command = CMD_WRITE_BUF;
				emit.sector  = SECTOR_W'(sector_q);
				emit.pos     = POS_OUT_W'(pos_q);
				emit.last    = 1'b1;
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	// control state and buffered sector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			result_valid_q  <= 1'b0;
			cached_sector_q <= '0;
			base_q          <= '0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit_valid;
			if (state_q == ST_WRITE) begin
				cached_sector_q <= sector_q;
				base_q          <= blk_q - TAG_W'(pos_q);
			end
		end
	end

	// request payload and divide-by-sector-size steps
	always_ff @(posedge clk) begin
		res_q <= emit;
		if (accept) begin
			action_q <= action;
			blk_q    <= blk_in;
		end
		// quotient estimate by reciprocal, low by at most one
		if (state_q == ST_DIV_MUL) begin
			prod_q <= PROD_W'(blk_q) * RECIP_C;
		end
		if (state_q == ST_DIV_REM) begin
			rem_q <= rem_full[REM_W-1:0];
		end
		// single correction step
		if (state_q == ST_DIV_FIX) begin
			if (rem_q >= BPS_R) begin
				sector_q <= quo + 1'b1;
				pos_q    <= POS_W'(rem_q - BPS_R);
			end else begin
				sector_q <= quo;
				pos_q    <= POS_W'(rem_q);
			end
		end
	end

	assign key             = blk_q;
	assign base            = base_q;
	assign result_valid    = result_valid_q;
	assign status          = res_q.status;
	assign command         = res_q.command;
	assign sector_number   = res_q.sector;
	assign slot_index      = res_q.slot;
	assign block_in_sector = res_q.pos;
	assign last            = res_q.last;

	// a non-final beat always belongs to a request still in progress
	a_mid_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("non-final result while idle");

	// an error beat is a lone final beat with no command
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> (last && command == CMD_NONE))
		else $error("error result malformed");

	// the buffered sector only moves at the end of a write miss
	a_sector_move: assert property (@(posedge clk) disable iff (!arst_n)
		(cached_sector_q != $past(cached_sector_q)) |-> ($past(state_q) == ST_WRITE))
		else $error("buffered sector changed outside a write miss");

endmodule

// ===== sim/fsbc_checker.sv =====
// Request codes shared by the bench, plus the checker that predicts and compares command beats.
`timescale 1ns / 1ps

package fsbc_tb_pkg;
	// Request kinds on the action port
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
endpackage

module fsbc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsbc_pkg::PART_W-1:0]     cfg_data,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            action,
	input  logic [fsbc_pkg::BLOCK_IN_W-1:0] block_number,
	input  logic                            result_valid,
	input  logic                            status,
	input  logic [fsbc_pkg::CMD_W-1:0]      command,
	input  logic [fsbc_pkg::SECTOR_W-1:0]   sector_number,
	input  logic [fsbc_pkg::SLOT_OUT_W-1:0] slot_index,
	input  logic [fsbc_pkg::POS_OUT_W-1:0]  block_in_sector,
	input  logic                            last,
	output int                              fail_count,
	output int                              pending
);
	import fsbc_pkg::*;
	import fsbc_tb_pkg::*;

	localparam int NUM_SLOTS     = 8;
	localparam int SECTOR_BLOCKS = 8;

	// Shadow copy of the registers and of the cache state
	logic [PART_W-1:0]     part_blocks;
	logic                  dev_ready;
	logic [SECTOR_W-1:0]   buf_sector;
	logic [BLOCK_IN_W-1:0] slot_tag [NUM_SLOTS];
	logic                  slot_ok [NUM_SLOTS];
	logic [SLOT_OUT_W-1:0] fill_ptr;

	// Commands still owed by the block, oldest first
	result_t due_cmds[$];

	task automatic owe(input logic st, input cmd_t cmd, input int sec, input int slot,
			input int pos, input logic fin);
		result_t r;
		r.status  = st;
		r.command = cmd;
		r.sector  = sec[SECTOR_W-1:0];
		r.slot    = slot[SLOT_OUT_W-1:0];
		r.pos     = pos[POS_OUT_W-1:0];
		r.last    = fin;
		due_cmds.push_back(r);
	endtask

	// Works out the command sequence of one request and updates the shadow state
	task automatic predict_commands(input logic act, input logic [BLOCK_IN_W-1:0] blk);
		int sec;
		int pos;
		int hit;
		sec = blk / SECTOR_BLOCKS;
		pos = blk % SECTOR_BLOCKS;
		hit = -1;
		if (!dev_ready || {1'b0, blk} >= part_blocks) begin
			owe(1'b1, CMD_NONE, 0, 0, 0, 1'b1);
		end else if (act == ACT_READ) begin
			if (sec == buf_sector) begin
				owe(1'b0, CMD_COPY_BUF, sec, 0, pos, 1'b1);
			end else begin
				for (int i = NUM_SLOTS - 1; i >= 0; i--)
					if (slot_ok[i] && slot_tag[i] == blk)
						hit = i;
				if (hit >= 0) begin
					owe(1'b0, CMD_COPY_SLOT, sec, hit, 0, 1'b1);
				end else begin
					slot_tag[fill_ptr] = blk;
					slot_ok[fill_ptr]  = 1'b1;
					owe(1'b0, CMD_FILL_SLOT, sec, fill_ptr, 0, 1'b1);
					fill_ptr = fill_ptr + 1'b1;
				end
			end
		end else if (sec == buf_sector) begin
			owe(1'b0, CMD_WRITE_BUF, sec, 0, pos, 1'b1);
		end else begin
			// write-back of the old sector, then swap in the new one
			owe(1'b0, CMD_ERASE, buf_sector, 0, 0, 1'b0);
			owe(1'b0, CMD_PROGRAM, buf_sector, 0, 0, 1'b0);
			for (int i = 0; i < NUM_SLOTS; i++)
				if (slot_ok[i] && slot_tag[i] / SECTOR_BLOCKS == buf_sector)
					owe(1'b0, CMD_REFRESH, buf_sector, i, slot_tag[i] % SECTOR_BLOCKS, 1'b0);
			owe(1'b0, CMD_LOAD, sec, 0, 0, 1'b0);
			owe(1'b0, CMD_WRITE_BUF, sec, 0, pos, 1'b1);
			buf_sector = sec[SECTOR_W-1:0];
		end
	endtask

	task automatic report(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Config writes, then the result beat, then the request beat, all sampled at the edge
	always @(posedge clk or negedge arst_n) begin
		result_t exp;
		if (!arst_n) begin
			part_blocks = '0;
			dev_ready   = 1'b0;
			buf_sector  = '0;
			fill_ptr    = '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_tag[i] = '0;
				slot_ok[i]  = 1'b0;
			end
			due_cmds.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PARTITION_BLOCKS)
					part_blocks = cfg_data;
				else if (cfg_index == REG_DEVICE_READY)
					dev_ready = cfg_data[0];
			end
			if (result_valid) begin
				if (due_cmds.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual command %0d",
						$time, command);
					fail_count++;
				end else begin
					exp = due_cmds.pop_front();
					report("status", exp.status, status);
					report("command", exp.command, command);
					report("sector_number", exp.sector, sector_number);
					report("slot_index", exp.slot, slot_index);
					report("block_in_sector", exp.pos, block_in_sector);
					report("last", exp.last, last);
				end
			end
			if (start && !busy)
				predict_commands(action, block_number);
		end
		pending = due_cmds.size();
	end

endmodule

// ===== sim/flash_sector_and_block_cache_control_top_tb.sv =====
// Stimulus and verdict for the flash sector and block cache controller.
`timescale 1ns / 1ps

module flash_sector_and_block_cache_control_top_tb;
	import fsbc_pkg::*;
	import fsbc_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [PART_W-1:0]     cfg_data;
	logic                  start;
	logic                  busy;
	logic                  action;
	logic [BLOCK_IN_W-1:0] block_number;
	logic                  result_valid;
	logic                  status;
	logic [CMD_W-1:0]      command;
	logic [SECTOR_W-1:0]   sector_number;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [POS_OUT_W-1:0]  block_in_sector;
	logic                  last;
	int                    fail_count;
	int                    pending;
	int                    cycles = 0;
	bit                    gaps_on;
	int                    cur_part;

	flash_sector_and_block_cache_control_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .action(action), .block_number(block_number),
		.result_valid(result_valid), .status(status), .command(command),
		.sector_number(sector_number), .slot_index(slot_index),
		.block_in_sector(block_in_sector), .last(last)
	);

	fsbc_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .action(action), .block_number(block_number),
		.result_valid(result_valid), .status(status), .command(command),
		.sector_number(sector_number), .slot_index(slot_index),
		.block_in_sector(block_in_sector), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("flash_sector_and_block_cache_control_top_tb: FAIL");
			$finish;
		end
	end

	// One register write; returns on a fresh edge
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[PART_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One request beat; start stays up until the block takes it
	task automatic send_req(input logic act, input logic [BLOCK_IN_W-1:0] blk);
		bit took;
		if (gaps_on && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		block_number <= blk;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	// Hold off until every owed command has come and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Mostly a few neighboring sectors, so hits and refreshes happen; some noise
	// and some blocks right at the partition end
	function automatic logic [BLOCK_IN_W-1:0] pick_block(input int base_sec, input int part);
		int r;
		int b;
		r = $urandom_range(0, 99);
		if (r < 70)
			b = (base_sec + $urandom_range(0, 5)) * 8 + $urandom_range(0, 7);
		else if (r < 85)
			b = $urandom_range(0, 65535);
		else
			b = part - 2 + $urandom_range(0, 3);
		if (b < 0)
			b = $urandom_range(0, 3);
		return b[BLOCK_IN_W-1:0];
	endfunction

	task automatic run_random(input int n, input int base_sec);
		for (int k = 0; k < n; k++)
			send_req($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, pick_block(base_sec, cur_part));
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		start        <= 1'b0;
		action       <= ACT_READ;
		block_number <= '0;
		gaps_on      = 1'b1;
		cur_part     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset: device not ready, everything rejected
		send_req(ACT_READ, 16'h0000);
		send_req(ACT_WRITE, 16'hFFFF);
		drain();

		// Ready but empty partition
		cfg_write(REG_DEVICE_READY, 1);
		send_req(ACT_READ, 16'h0000);
		drain();

		// Full partition: buffer hits, slot fills and hits, write misses
		cfg_write(REG_PARTITION_BLOCKS, 65536);
		cur_part = 65536;
		send_req(ACT_READ, 16'd0);
		send_req(ACT_READ, 16'd7);
		send_req(ACT_WRITE, 16'd5);
		send_req(ACT_READ, 16'd8);
		send_req(ACT_READ, 16'd9);
		send_req(ACT_READ, 16'd10);
		send_req(ACT_READ, 16'd8);
		send_req(ACT_WRITE, 16'd12);
		send_req(ACT_WRITE, 16'd100);
		send_req(ACT_READ, 16'd9);
		send_req(ACT_READ, 16'd65535);
		send_req(ACT_WRITE, 16'd65535);
		// every slot ends up in sector 2, block 16 swaps sector 2 in, block 0 flushes it with eight refreshes
		for (int b = 16; b < 24; b++)
			send_req(ACT_READ, b[BLOCK_IN_W-1:0]);
		send_req(ACT_WRITE, 16'd16);
		send_req(ACT_WRITE, 16'd0);
		drain();

		// Small partition, boundary blocks and out-of-range noise
		cfg_write(REG_PARTITION_BLOCKS, 1000);
		cur_part = 1000;
		send_req(ACT_READ, 16'd999);
		send_req(ACT_WRITE, 16'd1000);
		run_random(40, 0);
		drain();

		// One short of full: the top block is rejected
		cfg_write(REG_PARTITION_BLOCKS, 65535);
		cur_part = 65535;
		run_random(30, 8184);
		drain();

		// Not ready again
		cfg_write(REG_DEVICE_READY, 0);
		run_random(5, 100);
		drain();

		// Full partition, first a stretch with no gaps, a pause to empty, then more
		cfg_write(REG_DEVICE_READY, 1);
		cfg_write(REG_PARTITION_BLOCKS, 65536);
		cur_part = 65536;
		gaps_on = 1'b0;
		run_random(30, 20);
		gaps_on = 1'b1;
		drain();
		run_random(20, 4000);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("flash_sector_and_block_cache_control_top_tb: PASS");
		else
			$display("flash_sector_and_block_cache_control_top_tb: FAIL");
		$finish;
	end

endmodule
